FILE: hdl/spr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the slotted page record store.
// No dependencies; every other file imports this package.
package spr_pkg;

  localparam int PAGE_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 8;
  localparam int SLOT_BYTES_DEF   = 4;

  localparam int COUNT_W     = 10;
  localparam int SLOT_DEPTH  = 1 << COUNT_W;
  localparam int MAX_RECORDS = SLOT_DEPTH - 1;
  localparam int LEN_W       = 13;
  localparam int IDX_W       = 12;
  localparam int BYTE_W      = 8;
  localparam int STATUS_W    = 3;

  localparam logic [BYTE_W-1:0] VERSION_BYTE = 8'd1;

  typedef enum logic [1:0] {
    CMD_INIT,
    CMD_BEGIN,
    CMD_BYTE,
    CMD_READ
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK,
    STAT_NO_SPACE,
    STAT_NOT_OPEN,
    STAT_BAD_SLOT,
    STAT_BAD_INDEX,
    STAT_STILL_OPEN
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SLOT,
    S_BYTE,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   read_byte;
    logic [LEN_W-1:0]    slot_length;
    logic                committed;
    logic [COUNT_W-1:0]  record_count;
    logic [LEN_W-1:0]    space_left;
  } result_t;

endpackage

FILE: hdl/spr_channels.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response beats.
// Depends on spr_pkg for field widths.
interface spr_req_if;
  import spr_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [LEN_W-1:0]   new_length;
  logic [BYTE_W-1:0]  data_byte;
  logic [COUNT_W-1:0] slot_sel;
  logic [IDX_W-1:0]   byte_index;

  modport source (output valid, command, new_length, data_byte, slot_sel, byte_index,
                  input ready);
  modport sink (input valid, command, new_length, data_byte, slot_sel, byte_index,
                output ready);
endinterface

interface spr_rsp_if;
  import spr_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   read_byte;
  logic [LEN_W-1:0]    slot_length;
  logic                committed;
  logic [COUNT_W-1:0]  record_count;
  logic [LEN_W-1:0]    space_left;

  modport source (output valid, status, read_byte, slot_length, committed, record_count,
                  space_left, input ready);
  modport sink (input valid, status, read_byte, slot_length, committed, record_count,
                space_left, output ready);
endinterface

FILE: hdl/spr_page_ram.sv
`timescale 1ns / 1ps
// Byte-wide page data memory: one write port, one registered read port.
// Depends on spr_pkg for the byte width.
module spr_page_ram #(
  parameter int DEPTH = spr_pkg::PAGE_BYTES_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [spr_pkg::BYTE_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [spr_pkg::BYTE_W-1:0] rdata
);
  import spr_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/spr_slot_ram.sv
`timescale 1ns / 1ps
// Slot directory memory: length and offset per slot, registered read.
// Depends on spr_pkg for slot count and length widths.
module spr_slot_ram #(
  parameter int OFF_W = 12
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [spr_pkg::COUNT_W-1:0] waddr,
  input  logic [spr_pkg::LEN_W-1:0]  wlen,
  input  logic [OFF_W-1:0]           woff,
  input  logic [spr_pkg::COUNT_W-1:0] raddr,
  output logic [spr_pkg::LEN_W-1:0]  rlen,
  output logic [OFF_W-1:0]           roff
);
  import spr_pkg::*;

  logic [LEN_W+OFF_W-1:0] mem [SLOT_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wlen, woff};
    end
    {rlen, roff} <= mem[raddr];
  end

endmodule

FILE: hdl/spr_ctrl.sv
`timescale 1ns / 1ps
// Command sequencer: page header state, open record tracking, slot commit
// and the two-step read. Depends on spr_pkg and spr_req_if.
module spr_ctrl #(
  parameter int PAGE_BYTES   = spr_pkg::PAGE_BYTES_DEF,
  parameter int HEADER_BYTES = spr_pkg::HEADER_BYTES_DEF,
  parameter int SLOT_BYTES   = spr_pkg::SLOT_BYTES_DEF,
  localparam int AW = $clog2(PAGE_BYTES)
) (
  input  logic                        clk,
  input  logic                        rst,
  spr_req_if.sink                     request,
  output logic                        res_valid,
  output spr_pkg::result_t            res,
  input  logic                        res_ready,
  output logic                        page_we,
  output logic [AW-1:0]               page_waddr,
  output logic [spr_pkg::BYTE_W-1:0]  page_wdata,
  output logic [AW-1:0]               page_raddr,
  input  logic [spr_pkg::BYTE_W-1:0]  page_rdata,
  output logic                        slot_we,
  output logic [spr_pkg::COUNT_W-1:0] slot_waddr,
  output logic [spr_pkg::LEN_W-1:0]   slot_wlen,
  output logic [AW-1:0]               slot_woff,
  output logic [spr_pkg::COUNT_W-1:0] slot_raddr,
  input  logic [spr_pkg::LEN_W-1:0]   slot_rlen,
  input  logic [AW-1:0]               slot_roff
);
  import spr_pkg::*;

  localparam int PW = AW + 1;
  localparam int CW = ((PW > LEN_W) ? PW : LEN_W) + 1;
  localparam int SW = ((AW > IDX_W) ? AW : IDX_W) + 1;

  ctrl_state_t        state, state_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [PW-1:0]      fp, fp_next;
  logic [PW-1:0]      slot_end, slot_end_next;
  logic               open, open_next;
  logic [PW-1:0]      wpos, wpos_next;
  logic [LEN_W-1:0]   remaining, remaining_next;
  logic [LEN_W-1:0]   open_len, open_len_next;
  logic [IDX_W-1:0]   rd_index, rd_index_next;
  status_t            pend_status, pend_status_next;
  logic [BYTE_W-1:0]  pend_byte, pend_byte_next;
  logic [LEN_W-1:0]   pend_slen, pend_slen_next;
  logic               pend_commit, pend_commit_next;

  logic               accept;
  cmd_t               cmd;
  logic [PW-1:0]      space;
  logic [PW-1:0]      commit_off;
  logic               fits;
  logic [SW-1:0]      rd_sum;

  assign accept     = request.valid && request.ready;
  assign cmd        = cmd_t'(request.command);
  assign space      = (fp > slot_end) ? (fp - slot_end) : '0;
  assign commit_off = fp - PW'(open_len);
  assign fits       = (CW'(request.new_length) + CW'(SLOT_BYTES)) <= CW'(space);
  assign rd_sum     = SW'(slot_roff) + SW'(rd_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      fp        <= PW'(PAGE_BYTES);
      slot_end  <= PW'(HEADER_BYTES);
      open      <= 1'b0;
      wpos      <= '0;
      remaining <= '0;
      open_len  <= '0;
    end else begin
      count     <= count_next;
      fp        <= fp_next;
      slot_end  <= slot_end_next;
      open      <= open_next;
      wpos      <= wpos_next;
      remaining <= remaining_next;
      open_len  <= open_len_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_index    <= rd_index_next;
    pend_status <= pend_status_next;
    pend_byte   <= pend_byte_next;
    pend_slen   <= pend_slen_next;
    pend_commit <= pend_commit_next;
  end

  always_comb begin
    state_next       = state;
    count_next       = count;
    fp_next          = fp;
    slot_end_next    = slot_end;
    open_next        = open;
    wpos_next        = wpos;
    remaining_next   = remaining;
    open_len_next    = open_len;
    rd_index_next    = rd_index;
    pend_status_next = pend_status;
    pend_byte_next   = pend_byte;
    pend_slen_next   = pend_slen;
    pend_commit_next = pend_commit;

    request.ready = (state == S_IDLE);
    res_valid     = 1'b0;
    page_we       = 1'b0;
    page_waddr    = wpos[AW-1:0];
    page_wdata    = request.data_byte;
    page_raddr    = rd_sum[AW-1:0];
    slot_we       = 1'b0;
    slot_waddr    = count;
    slot_wlen     = open_len;
    slot_woff     = commit_off[AW-1:0];
    slot_raddr    = request.slot_sel;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          pend_status_next = STAT_OK;
          pend_byte_next   = '0;
          pend_slen_next   = '0;
          pend_commit_next = 1'b0;
          state_next       = S_DONE;
          unique case (cmd)
            CMD_INIT: begin
              page_we        = 1'b1;
              page_waddr     = '0;
              page_wdata     = VERSION_BYTE;
              count_next     = '0;
              fp_next        = PW'(PAGE_BYTES);
              slot_end_next  = PW'(HEADER_BYTES);
              open_next      = 1'b0;
              wpos_next      = '0;
              remaining_next = '0;
              open_len_next  = '0;
            end
            CMD_BEGIN: begin
              if (open) begin
                pend_status_next = STAT_STILL_OPEN;
              end else if (count == COUNT_W'(MAX_RECORDS) || !fits) begin
                pend_status_next = STAT_NO_SPACE;
              end else if (request.new_length == '0) begin
                // empty record: slot commits at once, offset is the free pointer
                slot_we          = 1'b1;
                slot_wlen        = '0;
                slot_woff        = fp[AW-1:0];
                count_next       = count + 1'b1;
                slot_end_next    = slot_end + PW'(SLOT_BYTES);
                pend_commit_next = 1'b1;
              end else begin
                open_next      = 1'b1;
                open_len_next  = request.new_length;
                wpos_next      = fp - PW'(request.new_length);
                remaining_next = request.new_length;
              end
            end
            CMD_BYTE: begin
              if (!open) begin
                pend_status_next = STAT_NOT_OPEN;
              end else begin
                page_we        = 1'b1;
                wpos_next      = wpos + 1'b1;
                remaining_next = remaining - 1'b1;
                if (remaining == LEN_W'(1)) begin
                  slot_we          = 1'b1;
                  count_next       = count + 1'b1;
                  fp_next          = commit_off;
                  slot_end_next    = slot_end + PW'(SLOT_BYTES);
                  open_next        = 1'b0;
                  wpos_next        = '0;
                  remaining_next   = '0;
                  open_len_next    = '0;
                  pend_commit_next = 1'b1;
                end
              end
            end
            CMD_READ: begin
              rd_index_next = request.byte_index;
              if (request.slot_sel >= count) begin
                pend_status_next = STAT_BAD_SLOT;
              end else begin
                state_next = S_SLOT;
              end
            end
            default: begin
              pend_status_next = STAT_OK;
            end
          endcase
        end
      end
      S_SLOT: begin
        // slot entry is back from the directory
        pend_slen_next = slot_rlen;
        if (LEN_W'(rd_index) >= slot_rlen) begin
          pend_status_next = STAT_BAD_INDEX;
          state_next       = S_DONE;
        end else begin
          state_next = S_BYTE;
        end
      end
      S_BYTE: begin
        pend_byte_next = page_rdata;
        state_next     = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.status       = pend_status;
    res.read_byte    = pend_byte;
    res.slot_length  = pend_slen;
    res.committed    = pend_commit;
    res.record_count = count;
    res.space_left   = LEN_W'(space);
  end

  a_open_has_bytes: assert property (@(posedge clk) disable iff (rst)
    open |-> remaining != '0)
    else $error("record open with no bytes due");

  a_slots_below_fp: assert property (@(posedge clk) disable iff (rst)
    slot_end <= fp)
    else $error("slot array overran free pointer");

  a_commit_is_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.committed |-> res.status == STAT_OK)
    else $error("commit reported with error status");

  a_read_fetches: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_READ && request.slot_sel < count |=> state == S_SLOT)
    else $error("valid slot read skipped directory fetch");

endmodule

FILE: hdl/slotted_page_record_store_top.sv
`timescale 1ns / 1ps
// Slotted page record store top: sequencer, page memory, slot directory
// and response register. Depends on spr_pkg, spr_channels and submodules.
// Order: init, begin and record byte go from the accepted request to S_DONE
//   and then the response register; read goes through S_SLOT (slot directory
//   fetch) and S_BYTE (page byte fetch) before S_DONE, skipping S_BYTE on a
//   bad index and both on a bad slot; each fetch is a registered memory read.
// A new request is taken only in S_IDLE, once the last response has gone to
//   the response register, so one request is finished before the next.
// Reset (rst, synchronous): empty page, free pointer at the page end, no
//   record open. Memory contents are not cleared; there is no clearing pass.
module slotted_page_record_store_top #(
  parameter int PAGE_BYTES   = spr_pkg::PAGE_BYTES_DEF,
  parameter int HEADER_BYTES = spr_pkg::HEADER_BYTES_DEF,
  parameter int SLOT_BYTES   = spr_pkg::SLOT_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  spr_req_if.sink    request,
  spr_rsp_if.source  response
);
  import spr_pkg::*;

  localparam int AW = $clog2(PAGE_BYTES);

  // sequencer to response register
  logic    res_valid;
  logic    res_ready;
  result_t res;

  // response register; frees as the downstream takes the beat
  logic    out_valid;
  result_t out_q;

  // page memory port
  logic              page_we;
  logic [AW-1:0]     page_waddr;
  logic [BYTE_W-1:0] page_wdata;
  logic [AW-1:0]     page_raddr;
  logic [BYTE_W-1:0] page_rdata;

  // slot directory port
  logic               slot_we;
  logic [COUNT_W-1:0] slot_waddr;
  logic [LEN_W-1:0]   slot_wlen;
  logic [AW-1:0]      slot_woff;
  logic [COUNT_W-1:0] slot_raddr;
  logic [LEN_W-1:0]   slot_rlen;
  logic [AW-1:0]      slot_roff;

  spr_ctrl #(
    .PAGE_BYTES  (PAGE_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .SLOT_BYTES  (SLOT_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .page_we   (page_we),
    .page_waddr(page_waddr),
    .page_wdata(page_wdata),
    .page_raddr(page_raddr),
    .page_rdata(page_rdata),
    .slot_we   (slot_we),
    .slot_waddr(slot_waddr),
    .slot_wlen (slot_wlen),
    .slot_woff (slot_woff),
    .slot_raddr(slot_raddr),
    .slot_rlen (slot_rlen),
    .slot_roff (slot_roff)
  );

  // record payload bytes plus the version byte at address zero
  spr_page_ram #(
    .DEPTH(PAGE_BYTES)
  ) u_page_ram (
    .clk  (clk),
    .we   (page_we),
    .waddr(page_waddr),
    .wdata(page_wdata),
    .raddr(page_raddr),
    .rdata(page_rdata)
  );

  // slot entries kept apart from the payload bytes; records never overlap
  // the slot array, so this gives the same answers as an in-page directory
  spr_slot_ram #(
    .OFF_W(AW)
  ) u_slot_ram (
    .clk  (clk),
    .we   (slot_we),
    .waddr(slot_waddr),
    .wlen (slot_wlen),
    .woff (slot_woff),
    .raddr(slot_raddr),
    .rlen (slot_rlen),
    .roff (slot_roff)
  );

  assign res_ready = !out_valid || response.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign response.valid        = out_valid;
  assign response.status       = out_q.status;
  assign response.read_byte    = out_q.read_byte;
  assign response.slot_length  = out_q.slot_length;
  assign response.committed    = out_q.committed;
  assign response.record_count = out_q.record_count;
  assign response.space_left   = out_q.space_left;

endmodule
